// ===== sv/itoa_pkg.sv =====
// Shared constants, character codes and helpers of the integer to ASCII converter.
// No dependencies; every other file imports this package.
package itoa_pkg;

    // Converted word width (8 to 32 with the fixed 32-bit value field).
    localparam int VALUE_BITS = 32;
    localparam int VALUE_W    = 32;
    localparam int MODE_W     = 2;
    localparam int CHAR_W     = 7;

    // Decimal digits needed for VALUE_BITS: floor(VALUE_BITS * log10(2)) + 1.
    localparam int DEC_DIGITS = (VALUE_BITS * 30103) / 100000 + 1;
    localparam int BCD_BITS   = 4 * DEC_DIGITS;
    localparam int CNT_W      = $clog2(VALUE_BITS + 1);
    localparam int LEFT_W     = $clog2(DEC_DIGITS + 1);

    // Format modes; the unused code falls back to unsigned decimal.
    localparam logic [MODE_W-1:0] MODE_SIGNED   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_UNSIGNED = 2'd1;
    localparam logic [MODE_W-1:0] MODE_HEX      = 2'd2;

    localparam logic [CHAR_W-1:0] CHAR_MINUS   = 7'h2D;
    localparam logic [CHAR_W-1:0] CHAR_ZERO    = 7'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE    = 7'h39;
    localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 7'h61;
    localparam logic [CHAR_W-1:0] CHAR_LOWER_F = 7'h66;

    // One digit (0..15) to its ASCII code, hex digits in lower case.
    function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] nib);
        logic [CHAR_W-1:0] ext;
        ext = CHAR_W'(nib);
        if (nib < 4'd10) begin
            digit_char = CHAR_ZERO + ext;
        end else begin
            digit_char = CHAR_LOWER_A + ext - 7'd10;
        end
    endfunction

endpackage

// ===== sv/itoa_intf.sv =====
// Stream interfaces of the integer to ASCII converter: number in, characters out.
// Depends on itoa_pkg for field widths.
interface itoa_in_if import itoa_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [VALUE_W-1:0]  value;
    logic [MODE_W-1:0]   format_mode;

    modport source (output valid, output value, output format_mode, input ready);
    modport sink   (input valid, input value, input format_mode, output ready);
endinterface

interface itoa_out_if import itoa_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [CHAR_W-1:0]   char_code;
    logic                last_char;

    modport source (output valid, output char_code, output last_char, input ready);
    modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

// ===== sv/integer_to_ascii_converter_core.sv =====
// Top level of the integer to ASCII converter: shift-add-3 sequencer and character output.
// Depends on itoa_pkg and the stream interfaces in itoa_intf.sv.
//
//   channel | dir | beat payload                | role
//   --------+-----+-----------------------------+-------------------------------------
//   i_in    | in  | value[31:0], format_mode[1:0]| one number per beat
//   o_out   | out | char_code[6:0], last_char   | one ASCII char per beat, MSB first
//
// Steps: decimal items take a load step, VALUE_BITS (32) shift-add-3 steps of the
// shared BCD adjust/shift unit, one step per leading zero digit skipped and a hand-off
// step out of the skip state, then emit the minus sign if negative and the digits, one
// character per step while o_out is not stalled. Hex items skip the conversion loop and
// carry no sign. i_in.ready is high only while idle; the next number is taken while the
// last char of the previous one still sits in the output register. A stalled o_out holds
// the sequencer in the sign and emit states. Reset (synchronous, active low) clears the
// state and o_out.valid.
module integer_to_ascii_converter_core import itoa_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    itoa_in_if.sink     i_in,
    itoa_out_if.source  o_out
);

    localparam logic [2:0] ST_IDLE = 3'd0;  // waiting for a number
    localparam logic [2:0] ST_CONV = 3'd1;  // double-dabble steps
    localparam logic [2:0] ST_SKIP = 3'd2;  // drop leading zero digits
    localparam logic [2:0] ST_SIGN = 3'd3;  // emit '-'
    localparam logic [2:0] ST_EMIT = 3'd4;  // emit digits, top nibble first

    logic [2:0]            r_state, n_state;
    logic [VALUE_BITS-1:0] r_bin, n_bin;     // binary bits still to shift in
    logic [BCD_BITS-1:0]   r_bcd, n_bcd;     // digit register, top digit at the MSBs
    logic [CNT_W-1:0]      r_cnt, n_cnt;     // conversion steps remaining
    logic [LEFT_W-1:0]     r_left, n_left;   // digits left in r_bcd
    logic                  r_neg, n_neg;
    logic                  r_ov, n_ov;       // output register holds a beat
    logic [CHAR_W-1:0]     r_char, n_char;
    logic                  r_last, n_last;

    logic [VALUE_BITS-1:0] w_word;
    logic [VALUE_BITS-1:0] w_mag;
    logic                  w_neg;
    logic [BCD_BITS-1:0]   w_adj;
    logic [3:0]            w_top;
    logic                  w_out_free;

    assign i_in.ready      = (r_state == ST_IDLE);
    assign o_out.valid     = r_ov;
    assign o_out.char_code = r_char;
    assign o_out.last_char = r_last;

    // Operand prep: two's complement magnitude in signed mode. The most negative
    // value negates to itself, which is already the right magnitude.
    assign w_word = i_in.value[VALUE_BITS-1:0];
    assign w_neg  = (i_in.format_mode == MODE_SIGNED) && w_word[VALUE_BITS-1];
    assign w_mag  = w_neg ? (~w_word + 1'b1) : w_word;

    assign w_top      = r_bcd[BCD_BITS-1 -: 4];
    assign w_out_free = !r_ov || o_out.ready;

    // Add-3 correction on every BCD digit of 5 or more, ahead of the shift.
    always_comb begin
        logic [3:0] nib;
        nib   = 4'd0;
        w_adj = r_bcd;
        for (int k = 0; k < DEC_DIGITS; k++) begin
            nib = r_bcd[4*k +: 4];
            w_adj[4*k +: 4] = (nib >= 4'd5) ? (nib + 4'd3) : nib;
        end
    end

    always_comb begin
        n_state = r_state;
        n_bin   = r_bin;
        n_bcd   = r_bcd;
        n_cnt   = r_cnt;
        n_left  = r_left;
        n_neg   = r_neg;
        n_ov    = r_ov;
        n_char  = r_char;
        n_last  = r_last;

        if (r_ov && o_out.ready) begin
            n_ov = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (i_in.valid) begin
                    n_neg  = w_neg;
                    n_left = LEFT_W'(DEC_DIGITS);
                    if (i_in.format_mode == MODE_HEX) begin
                        // nibbles are already the hex digits
                        n_bcd   = BCD_BITS'(w_mag);
                        n_state = ST_SKIP;
                    end else begin
                        n_bcd   = '0;
                        n_bin   = w_mag;
                        n_cnt   = CNT_W'(VALUE_BITS);
                        n_state = ST_CONV;
                    end
                end
            end
            ST_CONV: begin
                {n_bcd, n_bin} = {w_adj, r_bin} << 1;
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    n_state = ST_SKIP;
                end
            end
            ST_SKIP: begin
                // keep at least one digit so zero prints as '0'
                if (w_top == 4'd0 && r_left != LEFT_W'(1)) begin
                    n_bcd  = r_bcd << 4;
                    n_left = r_left - 1'b1;
                end else begin
                    n_state = r_neg ? ST_SIGN : ST_EMIT;
                end
            end
            ST_SIGN: begin
                if (w_out_free) begin
                    n_ov    = 1'b1;
                    n_char  = CHAR_MINUS;
                    n_last  = 1'b0;
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (w_out_free) begin
                    n_ov   = 1'b1;
                    n_char = digit_char(w_top);
                    n_last = (r_left == LEFT_W'(1));
                    n_bcd  = r_bcd << 4;
                    n_left = r_left - 1'b1;
                    if (r_left == LEFT_W'(1)) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ov    <= n_ov;
        end
    end

    // Datapath, no reset needed
    always_ff @(posedge i_clk) begin
        r_bin  <= n_bin;
        r_bcd  <= n_bcd;
        r_cnt  <= n_cnt;
        r_left <= n_left;
        r_neg  <= n_neg;
        r_char <= n_char;
        r_last <= n_last;
    end

endmodule

// ===== sv/itoa_checker.sv =====
// Port-level assertions for integer_to_ascii_converter_core, bound to the top level.
// Depends on itoa_pkg for the character codes.
module itoa_checker import itoa_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              i_in_ready,
    input logic              i_out_valid,
    input logic              i_out_ready,
    input logic [CHAR_W-1:0] i_char_code,
    input logic              i_last_char
);

    // stalled output beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_char_code) && $stable(i_last_char))
        else $error("output beat changed while stalled");

    // input ready drops once a number is taken, while it is converted
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("input ready right after an accepted number");

    // only '-', digits and lower-case hex letters come out
    a_char_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |->
            (i_char_code == CHAR_MINUS) ||
            (i_char_code >= CHAR_ZERO && i_char_code <= CHAR_NINE) ||
            (i_char_code >= CHAR_LOWER_A && i_char_code <= CHAR_LOWER_F))
        else $error("illegal character code");

    // a minus sign is always followed by digits
    a_minus_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_char_code == CHAR_MINUS) |-> !i_last_char)
        else $error("minus sign flagged as last character");

endmodule

bind integer_to_ascii_converter_core itoa_checker u_itoa_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_char_code (o_out.char_code),
    .i_last_char (o_out.last_char)
);

// ===== test/integer_to_ascii_converter_core_tb.sv =====
`timescale 1ns / 100ps
// Testbench for integer_to_ascii_converter_core: numbers in, ASCII characters out.
// Depends on itoa_pkg, the stream interfaces in itoa_intf.sv and the core itself.
module integer_to_ascii_converter_core_tb;
    import itoa_pkg::*;

    // The spare format code is not named in the package; the core treats it as unsigned.
    localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 60;   // margin beyond the longest item
    localparam int ITEMS_PER_PHASE = 37;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic [CHAR_W-1:0] code;
        logic              last;
    } char_beat_t;

    // Holds the characters still owed by the core, oldest first, and grades each
    // output beat against them.
    class char_scoreboard;
        char_beat_t owed_chars[$];
        int unsigned errors;

        function void note_number(logic [VALUE_W-1:0] value, logic [MODE_W-1:0] mode);
            logic [63:0]       mask;
            logic [63:0]       word;
            logic [63:0]       radix;
            logic [63:0]       rem;
            logic [CHAR_W-1:0] text[$];
            char_beat_t        beat;
            mask  = (64'd1 << VALUE_BITS) - 64'd1;
            word  = {32'd0, value} & mask;
            radix = (mode == MODE_HEX) ? 64'd16 : 64'd10;
            // Signed mode: take the magnitude; the most negative word maps onto itself,
            // which is exactly its magnitude read unsigned.
            if (mode == MODE_SIGNED && word[VALUE_BITS-1]) begin
                word = (~word + 64'd1) & mask;
            end
            do begin
                rem = word % radix;
                if (rem < 64'd10) begin
                    text.push_front(CHAR_ZERO + CHAR_W'(rem));
                end else begin
                    text.push_front(CHAR_LOWER_A + CHAR_W'(rem - 64'd10));
                end
                word = word / radix;
            end while (word != 64'd0);
            if (mode == MODE_SIGNED && value[VALUE_BITS-1]) begin
                text.push_front(CHAR_MINUS);
            end
            foreach (text[k]) begin
                beat.code = text[k];
                beat.last = (k == text.size() - 1);
                owed_chars.push_back(beat);
            end
        endfunction

        function void check_char(logic [CHAR_W-1:0] code, logic last);
            char_beat_t want;
            if (owed_chars.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS) begin
                    $display("unexpected char beat: code %h last %b", code, last);
                end
                return;
            end
            want = owed_chars.pop_front();
            if (code !== want.code || last !== want.last) begin
                errors++;
                if (errors <= MAX_REPORTS) begin
                    $display("char mismatch: expected code %h last %b, got code %h last %b",
                             want.code, want.last, code, last);
                end
            end
        endfunction

        function int unsigned outstanding();
            return owed_chars.size();
        endfunction

        // Anything still owed at the end is a failure too.
        function int unsigned close_out();
            if (owed_chars.size() != 0) begin
                errors++;
                $display("%0d char beats never arrived", owed_chars.size());
            end
            return errors;
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    itoa_in_if  num_if ();
    itoa_out_if chr_if ();

    integer_to_ascii_converter_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (num_if),
        .o_out   (chr_if)
    );

    char_scoreboard sb;
    int unsigned    in_idle_pct;
    int unsigned    out_stall_pct;
    int unsigned    cycle_count;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Watchdog: a hung handshake ends the run here.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Output side: grade each accepted char beat, then roll the next ready.
    always @(posedge i_clk) begin
        if (i_rst_n && chr_if.valid && chr_if.ready) begin
            sb.check_char(chr_if.char_code, chr_if.last_char);
        end
        chr_if.ready <= ($urandom_range(99) >= out_stall_pct);
    end

    // Present one number and hold it until the core takes it. valid is left high on
    // return so back-to-back beats never drop it; only an idle gap or drain_chars lowers it.
    task automatic send_number(input logic [VALUE_W-1:0] value,
                               input logic [MODE_W-1:0] mode);
        int gap;
        gap = 0;
        while ($urandom_range(99) < in_idle_pct && gap < 40) begin
            gap++;
        end
        if (gap > 0) begin
            num_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        num_if.valid       <= 1'b1;
        num_if.value       <= value;
        num_if.format_mode <= mode;
        do @(posedge i_clk); while (!(num_if.valid && num_if.ready));
        sb.note_number(num_if.value, num_if.format_mode);
    endtask

    // Pause the sender until every owed char has come out.
    task automatic drain_chars();
        num_if.valid <= 1'b0;
        while (sb.outstanding() != 0) @(posedge i_clk);
    endtask

    // Random words biased toward digit-count boundaries and the sign edge.
    function automatic logic [VALUE_W-1:0] pick_value();
        logic [VALUE_W-1:0] tens[10];
        tens = '{32'd1, 32'd10, 32'd100, 32'd1000, 32'd10000, 32'd100000, 32'd1000000,
                 32'd10000000, 32'd100000000, 32'd1000000000};
        case ($urandom_range(5))
            0: return $urandom;
            1: return $urandom >> $urandom_range(31);
            2: return $urandom_range(999);
            3: return 32'h8000_0000 + $urandom_range(15) - 32'd8;
            4: return tens[$urandom_range(9)] + $urandom_range(2) - 32'd1;
            default: return 32'hFFFF_FFFF - $urandom_range(20);
        endcase
    endfunction

    function automatic logic [MODE_W-1:0] pick_mode();
        if ($urandom_range(9) == 0) begin
            return MODE_SPARE;
        end
        return MODE_W'($urandom_range(2));
    endfunction

    initial begin
        int unsigned idle_plan[5];
        int unsigned stall_plan[5];
        sb = new();
        cycle_count        = 0;
        in_idle_pct        = 0;
        out_stall_pct      = 0;
        i_rst_n            = 1'b0;
        num_if.valid       = 1'b0;
        num_if.value       = '0;
        num_if.format_mode = MODE_SIGNED;
        chr_if.ready       = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: zero in every mode, the extremes, sign edge, digit-count edges.
        send_number(32'd0, MODE_SIGNED);
        send_number(32'd0, MODE_UNSIGNED);
        send_number(32'd0, MODE_HEX);
        send_number(32'd0, MODE_SPARE);
        send_number(32'hFFFF_FFFF, MODE_SIGNED);
        send_number(32'hFFFF_FFFF, MODE_UNSIGNED);
        send_number(32'hFFFF_FFFF, MODE_HEX);
        send_number(32'hFFFF_FFFF, MODE_SPARE);
        send_number(32'h8000_0000, MODE_SIGNED);   // most negative: full magnitude
        send_number(32'h8000_0000, MODE_UNSIGNED);
        send_number(32'h8000_0000, MODE_HEX);
        send_number(32'h7FFF_FFFF, MODE_SIGNED);
        send_number(32'd1, MODE_SIGNED);
        send_number(32'd9, MODE_UNSIGNED);
        send_number(32'd10, MODE_SIGNED);
        send_number(32'd999999999, MODE_UNSIGNED);
        send_number(32'd1000000000, MODE_SIGNED);
        send_number(32'hF, MODE_HEX);
        send_number(32'hA, MODE_HEX);
        send_number(32'h10, MODE_HEX);
        send_number(32'hDEAD_BEEF, MODE_HEX);
        send_number(32'h0123_4567, MODE_HEX);
        send_number(32'h89AB_CDEF, MODE_SIGNED);
        send_number(32'h5555_AAAA, MODE_SPARE);
        drain_chars();

        // Random phases; each one ends with the sender held until all chars are out.
        idle_plan  = '{0, 58, 0, 34, 0};
        stall_plan = '{0, 0, 58, 34, 0};
        for (int p = 0; p < 5; p++) begin
            in_idle_pct   = idle_plan[p];
            out_stall_pct = stall_plan[p];
            repeat (ITEMS_PER_PHASE) send_number(pick_value(), pick_mode());
            drain_chars();
        end

        out_stall_pct = 0;
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.close_out() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
